// ===== rtl/core/lbf_pkg.sv =====
// Lamp brightness filter package: sizes, register codes, queue entry and
// configuration structs, sequencer states.
// No dependencies; used by every module of the block.
`timescale 1ns / 1ps

package lbf_pkg;

  localparam int unsigned NUM_ROWS   = 10;
  localparam int unsigned NUM_COLS   = 18;
  localparam int unsigned LAMP_COUNT = NUM_ROWS * NUM_COLS;
  localparam int unsigned LAMP_AW    = $clog2(LAMP_COUNT);
  localparam int unsigned MAX_LEVELS = 64;
  localparam int unsigned MIN_LEVELS = 8;

  localparam int unsigned Q16_W   = 17;     // unsigned Q1.16, up to 1.0
  localparam int unsigned LVL_W   = 7;      // levels register
  localparam int unsigned INT_W   = 6;      // intensity / level
  localparam int unsigned FILT_W  = 22;     // Q6.16 filter value
  localparam int unsigned CNT_W   = 16;     // on-count and period length
  localparam int unsigned CYC_W   = 64;
  localparam int unsigned IDX_W   = 8;
  localparam int unsigned P1_W    = CNT_W + INT_W;   // count * top
  localparam int unsigned NUM_W   = P1_W + Q16_W;    // count * top * dimming
  localparam int unsigned PROD_W  = FILT_W + Q16_W;  // alpha * difference
  localparam int unsigned CFG_IW  = 2;

  localparam logic [Q16_W-1:0] ONE_Q16     = Q16_W'(65536);
  localparam logic [Q16_W-1:0] RISE_RESET  = Q16_W'(29491);
  localparam logic [Q16_W-1:0] FALL_RESET  = Q16_W'(2621);
  localparam logic [LVL_W-1:0] LVL_RESET   = LVL_W'(8);
  localparam logic [CNT_W-1:0] DELTA_MAX   = CNT_W'(65535);

  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QUEUE_AW    = $clog2(QUEUE_DEPTH);
  localparam int unsigned QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [CFG_IW-1:0] {
    CFG_DIMMING = 2'd0,
    CFG_RISE    = 2'd1,
    CFG_FALL    = 2'd2,
    CFG_LEVELS  = 2'd3
  } cfg_idx_e;

  localparam logic CMD_PERIOD  = 1'b0;
  localparam logic CMD_LAMP    = 1'b1;
  localparam logic KIND_PERIOD = 1'b0;
  localparam logic KIND_LAMP   = 1'b1;

  typedef struct packed {
    logic [Q16_W-1:0] dimming;
    logic [Q16_W-1:0] rise_alpha;
    logic [Q16_W-1:0] fall_alpha;
    logic [LVL_W-1:0] levels;
  } cfg_t;

  // One classified item between the front and the back
  typedef struct packed {
    logic             kind;
    logic             skip;
    logic             in_range;
    logic [IDX_W-1:0] idx;
    logic [CNT_W-1:0] count;
    logic [CNT_W-1:0] period;
  } job_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_CHECK,
    ST_DIV,
    ST_FMUL,
    ST_FUPD,
    ST_EMIT
  } back_state_e;

endpackage

// ===== rtl/core/lbf_front.sv =====
// Front end: accepts items, tracks the period reference and length, and
// turns each item into a queue entry. Depends on lbf_pkg.
`timescale 1ns / 1ps

module lbf_front (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic                       cmd_i,
  input  logic [63:0]                cycle_count_i,
  input  logic [7:0]                 light_index_i,
  input  logic [15:0]                on_count_i,
  input  logic                       full_i,
  output logic                       push_o,
  output lbf_pkg::job_t              job_o
);
  import lbf_pkg::*;

  logic [CYC_W-1:0] last_q, last_d;
  logic             primed_q, primed_d;
  logic [CNT_W-1:0] period_q, period_d;
  logic             pskip_q, pskip_d;
  logic [CYC_W-1:0] delta;
  logic             accept;
  logic             in_range;

  assign in_ready_o = !full_i;
  assign accept     = in_valid_i && !full_i;
  assign push_o     = accept;
  assign delta      = cycle_count_i - last_q;
  assign in_range   = light_index_i < IDX_W'(LAMP_COUNT);

  always_comb begin
    last_d   = last_q;
    primed_d = primed_q;
    period_d = period_q;
    pskip_d  = pskip_q;
    job_o    = '0;
    if (cmd_i == CMD_PERIOD) begin
      job_o.kind = KIND_PERIOD;
      if (!primed_q) begin
        job_o.skip = 1'b1;
        if (accept) begin
          last_d   = cycle_count_i;
          primed_d = 1'b1;
        end
      end else if (delta == '0) begin
        job_o.skip = 1'b1;
        if (accept) pskip_d = 1'b1;
      end else begin
        job_o.skip = 1'b0;
        if (accept) begin
          last_d   = cycle_count_i;
          period_d = (delta[CYC_W-1:CNT_W] != '0) ? DELTA_MAX : delta[CNT_W-1:0];
          pskip_d  = 1'b0;
        end
      end
    end else begin
      job_o.kind     = KIND_LAMP;
      job_o.in_range = in_range;
      job_o.idx      = light_index_i;
      job_o.count    = on_count_i;
      job_o.period   = period_q;
      job_o.skip     = !in_range || pskip_q || (period_q == '0);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_q   <= '0;
      primed_q <= 1'b0;
      period_q <= '0;
      pskip_q  <= 1'b1;
    end else begin
      last_q   <= last_d;
      primed_q <= primed_d;
      period_q <= period_d;
      pskip_q  <= pskip_d;
    end
  end

endmodule

// ===== rtl/core/lbf_queue.sv =====
// Short FIFO of classified items between the front and the back.
// Depends on lbf_pkg.
`timescale 1ns / 1ps

module lbf_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  lbf_pkg::job_t job_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic          empty_o,
  output lbf_pkg::job_t job_o
);
  import lbf_pkg::*;

  job_t                entry_q [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0] wr_ptr_q, wr_ptr_d;
  logic [QUEUE_AW-1:0] rd_ptr_q, rd_ptr_d;
  logic [QUEUE_CW-1:0] count_q, count_d;

  assign full_o  = count_q == QUEUE_CW'(QUEUE_DEPTH);
  assign empty_o = count_q == '0;
  assign job_o   = entry_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) entry_q[wr_ptr_q] <= job_i;
  end

endmodule

// ===== rtl/core/lbf_back.sv =====
// Back end: per-lamp sequencer with scaling multiplies, a bit-per-cycle
// intensity divider, the filter store and the result register.
// Depends on lbf_pkg.
`timescale 1ns / 1ps

module lbf_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  lbf_pkg::cfg_t cfg_i,
  input  logic          empty_i,
  input  lbf_pkg::job_t job_i,
  output logic          pop_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output logic          kind_o,
  output logic          skipped_o,
  output logic [7:0]    lamp_number_o,
  output logic [5:0]    raw_intensity_o,
  output logic [5:0]    lamp_level_o
);
  import lbf_pkg::*;

  back_state_e        state_q, state_d;
  job_t               job_q, job_d;
  logic [P1_W-1:0]    p1_q, p1_d;
  logic [NUM_W-1:0]   num_q, num_d;
  logic [FILT_W-1:0]  rem_q, rem_d;
  logic [FILT_W-1:0]  dsh_q, dsh_d;
  logic [INT_W-1:0]   quo_q, quo_d;
  logic [2:0]         cnt_q, cnt_d;
  logic [INT_W-1:0]   inten_q, inten_d;
  logic [FILT_W-1:0]  f_q, f_d;
  logic               rise_q, rise_d;
  logic [PROD_W-1:0]  m_q, m_d;

  logic [FILT_W-1:0]  mem [LAMP_COUNT];
  logic [LAMP_COUNT-1:0] valid_q;
  logic [FILT_W-1:0]  rd_data_q;
  logic               rd_valid_q;
  logic               mem_re, mem_we;

  logic               out_valid_q;
  logic               kind_q, skipped_q;
  logic [IDX_W-1:0]   lamp_q;
  logic [INT_W-1:0]   raw_q, level_q;

  logic [INT_W-1:0]   top;
  logic [NUM_W-17:0]  n_hi;
  logic               div_ge;
  logic [INT_W-1:0]   quo_next;
  logic [FILT_W-1:0]  t_val;
  logic               t_gt;
  logic [FILT_W-1:0]  diff;
  logic [Q16_W-1:0]   alpha;
  logic [PROD_W-1:0]  m_round;
  logic [FILT_W-1:0]  adj;
  logic [FILT_W-1:0]  f_new;
  logic [FILT_W:0]    lvl_sum;
  logic [INT_W-1:0]   level;
  logic               emit_fire;

  assign top      = INT_W'(cfg_i.levels - LVL_W'(1));
  assign n_hi     = num_q[NUM_W-1:16];
  assign div_ge   = rem_q >= dsh_q;
  assign quo_next = {quo_q[INT_W-2:0], div_ge};
  assign t_val    = {inten_q, 16'b0};
  assign t_gt     = t_val > f_q;
  assign diff     = t_gt ? (t_val - f_q) : (f_q - t_val);
  assign alpha    = t_gt ? cfg_i.rise_alpha : cfg_i.fall_alpha;
  assign m_round  = m_q + PROD_W'(32768);
  assign adj      = m_round[FILT_W+15:16];
  assign f_new    = rise_q ? (f_q + adj) : (f_q - adj);
  assign lvl_sum  = {1'b0, f_q} + (FILT_W + 1)'(32768);
  assign level    = (lvl_sum[FILT_W:16] > 7'd63) ? 6'd63 : lvl_sum[21:16];
  assign emit_fire = (state_q == ST_EMIT) && (!out_valid_q || out_ready_i);

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (!empty_i) begin
          state_d = (job_i.kind == KIND_LAMP && job_i.in_range) ? ST_MUL : ST_EMIT;
        end
      end
      ST_MUL:   state_d = job_q.skip ? ST_EMIT : ST_CHECK;
      ST_CHECK: state_d = (n_hi >= {1'b0, job_q.period, 6'b0}) ? ST_FMUL : ST_DIV;
      ST_DIV:   state_d = (cnt_q == '0) ? ST_FMUL : ST_DIV;
      ST_FMUL:  state_d = ST_FUPD;
      ST_FUPD:  state_d = ST_EMIT;
      ST_EMIT:  state_d = emit_fire ? ST_IDLE : ST_EMIT;
      default:  state_d = ST_IDLE;
    endcase
  end

  // Datapath and control outputs
  always_comb begin
    job_d   = job_q;
    p1_d    = p1_q;
    num_d   = num_q;
    rem_d   = rem_q;
    dsh_d   = dsh_q;
    quo_d   = quo_q;
    cnt_d   = cnt_q;
    inten_d = inten_q;
    f_d     = f_q;
    rise_d  = rise_q;
    m_d     = m_q;
    pop_o   = 1'b0;
    mem_re  = 1'b0;
    mem_we  = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (!empty_i) begin
          pop_o   = 1'b1;
          job_d   = job_i;
          f_d     = '0;
          inten_d = '0;
          p1_d    = P1_W'(job_i.count) * P1_W'(top);
          mem_re  = job_i.kind == KIND_LAMP && job_i.in_range;
        end
      end
      ST_MUL: begin
        f_d   = rd_valid_q ? rd_data_q : '0;
        num_d = NUM_W'(p1_q) * NUM_W'(cfg_i.dimming);
      end
      ST_CHECK: begin
        // quotient of 64 or more clamps at once; otherwise six divide steps
        if (n_hi >= {1'b0, job_q.period, 6'b0}) begin
          inten_d = top;
        end else begin
          rem_d = n_hi[FILT_W-1:0];
          dsh_d = {1'b0, job_q.period, 5'b0};
          quo_d = '0;
          cnt_d = 3'(INT_W - 1);
        end
      end
      ST_DIV: begin
        if (div_ge) rem_d = rem_q - dsh_q;
        quo_d = quo_next;
        dsh_d = dsh_q >> 1;
        cnt_d = cnt_q - 1'b1;
        if (cnt_q == '0) inten_d = (quo_next > top) ? top : quo_next;
      end
      ST_FMUL: begin
        rise_d = t_gt;
        m_d    = PROD_W'(diff) * PROD_W'(alpha);
      end
      ST_FUPD: begin
        f_d    = f_new;
        mem_we = 1'b1;
      end
      ST_EMIT: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    job_q   <= job_d;
    p1_q    <= p1_d;
    num_q   <= num_d;
    rem_q   <= rem_d;
    dsh_q   <= dsh_d;
    quo_q   <= quo_d;
    cnt_q   <= cnt_d;
    inten_q <= inten_d;
    f_q     <= f_d;
    rise_q  <= rise_d;
    m_q     <= m_d;
  end

  // Filter store; an entry never written reads as zero
  always_ff @(posedge clk_i) begin
    if (mem_we) mem[job_q.idx[LAMP_AW-1:0]] <= f_new;
    if (mem_re) rd_data_q <= mem[job_i.idx[LAMP_AW-1:0]];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q    <= '0;
      rd_valid_q <= 1'b0;
    end else begin
      if (mem_we) valid_q[job_q.idx[LAMP_AW-1:0]] <= 1'b1;
      if (mem_re) rd_valid_q <= valid_q[job_i.idx[LAMP_AW-1:0]];
    end
  end

  // Result register: hold until the transfer completes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (emit_fire) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit_fire) begin
      kind_q    <= job_q.kind;
      skipped_q <= job_q.skip;
      lamp_q    <= (job_q.kind == KIND_LAMP) ? job_q.idx : '0;
      raw_q     <= inten_q;
      level_q   <= (job_q.kind == KIND_LAMP) ? level : '0;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign kind_o          = kind_q;
  assign skipped_o       = skipped_q;
  assign lamp_number_o   = lamp_q;
  assign raw_intensity_o = raw_q;
  assign lamp_level_o    = level_q;

endmodule

// ===== rtl/core/lamp_brightness_filter_unit.sv =====
// Lamp brightness filter top level: configuration registers, front end,
// item queue and back end. Depends on lbf_pkg, lbf_front, lbf_queue, lbf_back.
// Back path: period items and out-of-range lamps pass ST_IDLE then ST_EMIT;
// skipped lamps add ST_MUL; updated lamps add ST_MUL, ST_CHECK, ST_DIV (bypassed
// when clamped early), ST_FMUL, ST_FUPD. The next item leaves the queue only
// after ST_EMIT loads the result register. Reset clears period state and filter.
`timescale 1ns / 1ps

module lamp_brightness_filter_unit (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [lbf_pkg::CFG_IW-1:0]  cfg_idx_i,
  input  logic [lbf_pkg::Q16_W-1:0]   cfg_data_i,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic                        cmd_i,
  input  logic [63:0]                 cycle_count_i,
  input  logic [7:0]                  light_index_i,
  input  logic [15:0]                 on_count_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic                        kind_o,
  output logic                        skipped_o,
  output logic [7:0]                  lamp_number_o,
  output logic [5:0]                  raw_intensity_o,
  output logic [5:0]                  lamp_level_o
);
  import lbf_pkg::*;

  cfg_t             cfg_q;
  logic [Q16_W-1:0] sat_val;
  logic [LVL_W-1:0] lvl_val;
  logic             push, pop, full, empty;
  job_t             front_job, queue_job;

  assign sat_val = (cfg_data_i > ONE_Q16) ? ONE_Q16 : cfg_data_i;
  assign lvl_val = (cfg_data_i < Q16_W'(MIN_LEVELS)) ? LVL_W'(MIN_LEVELS) :
                   (cfg_data_i > Q16_W'(MAX_LEVELS)) ? LVL_W'(MAX_LEVELS) :
                   cfg_data_i[LVL_W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.dimming    <= ONE_Q16;
      cfg_q.rise_alpha <= RISE_RESET;
      cfg_q.fall_alpha <= FALL_RESET;
      cfg_q.levels     <= LVL_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_DIMMING: cfg_q.dimming    <= sat_val;
        CFG_RISE:    cfg_q.rise_alpha <= sat_val;
        CFG_FALL:    cfg_q.fall_alpha <= sat_val;
        CFG_LEVELS:  cfg_q.levels     <= lvl_val;
        default: begin
        end
      endcase
    end
  end

  lbf_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .cmd_i         (cmd_i),
    .cycle_count_i (cycle_count_i),
    .light_index_i (light_index_i),
    .on_count_i    (on_count_i),
    .full_i        (full),
    .push_o        (push),
    .job_o         (front_job)
  );

  lbf_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .job_i   (front_job),
    .full_o  (full),
    .pop_i   (pop),
    .empty_o (empty),
    .job_o   (queue_job)
  );

  lbf_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_i           (cfg_q),
    .empty_i         (empty),
    .job_i           (queue_job),
    .pop_o           (pop),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .kind_o          (kind_o),
    .skipped_o       (skipped_o),
    .lamp_number_o   (lamp_number_o),
    .raw_intensity_o (raw_intensity_o),
    .lamp_level_o    (lamp_level_o)
  );

endmodule

// ===== tb/lamp_brightness_filter_unit_tb.sv =====
// Self-checking testbench for lamp_brightness_filter_unit: directed period and lamp
// cases, register extremes, output backpressure and random traffic against a
// built-in brightness predictor. Depends on lbf_pkg and the RTL of the block.
`timescale 1ns / 1ps

module lamp_brightness_filter_unit_tb;

  import lbf_pkg::*;

  localparam logic [63:0] HALF_Q16 = 64'd32768;

  typedef struct packed {
    logic             kind;
    logic             skipped;
    logic [7:0]       lamp;
    logic [INT_W-1:0] raw;
    logic [INT_W-1:0] level;
  } lamp_res_t;

  logic                clk_i;
  logic                rst_ni;
  logic                cfg_we_i;
  logic [CFG_IW-1:0]   cfg_idx_i;
  logic [Q16_W-1:0]    cfg_data_i;
  logic                in_valid_i;
  logic                in_ready_o;
  logic                cmd_i;
  logic [63:0]         cycle_count_i;
  logic [7:0]          light_index_i;
  logic [15:0]         on_count_i;
  logic                out_valid_o;
  logic                out_ready_i;
  logic                kind_o;
  logic                skipped_o;
  logic [7:0]          lamp_number_o;
  logic [5:0]          raw_intensity_o;
  logic [5:0]          lamp_level_o;

  // Predictor state: configuration copy, period tracking, per-lamp filter values
  cfg_t               lamp_cfg;
  logic [63:0]        ref_cycles;
  logic               have_ref;
  logic [CNT_W-1:0]   period_len;
  logic               period_skipped;
  logic [FILT_W-1:0]  filt_mem [LAMP_COUNT];

  lamp_res_t          expected_q [$];
  int                 err_cnt;
  bit                 src_idle_en;
  bit                 sink_idle_en;
  int                 long_hold_cycles;
  logic [63:0]        stim_now;
  logic [63:0]        stim_delta;

  lamp_brightness_filter_unit i_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_data_i      (cfg_data_i),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .cmd_i           (cmd_i),
    .cycle_count_i   (cycle_count_i),
    .light_index_i   (light_index_i),
    .on_count_i      (on_count_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .kind_o          (kind_o),
    .skipped_o       (skipped_o),
    .lamp_number_o   (lamp_number_o),
    .raw_intensity_o (raw_intensity_o),
    .lamp_level_o    (lamp_level_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #20_000_000;
    $display("** lamp_brightness_filter_unit: FAILED **");
    $finish;
  end

  function automatic logic [INT_W-1:0] round_filter(input logic [FILT_W-1:0] f);
    logic [63:0] lv;
    lv = (64'(f) + HALF_Q16) >> 16;
    return (lv > 64'd63) ? INT_W'(63) : lv[INT_W-1:0];
  endfunction

  function automatic void write_model_reg(input cfg_idx_e idx, input logic [Q16_W-1:0] d);
    case (idx)
      CFG_DIMMING: lamp_cfg.dimming    = (d > ONE_Q16) ? ONE_Q16 : d;
      CFG_RISE:    lamp_cfg.rise_alpha = (d > ONE_Q16) ? ONE_Q16 : d;
      CFG_FALL:    lamp_cfg.fall_alpha = (d > ONE_Q16) ? ONE_Q16 : d;
      CFG_LEVELS: begin
        if (d < Q16_W'(MIN_LEVELS)) lamp_cfg.levels = LVL_W'(MIN_LEVELS);
        else if (d > Q16_W'(MAX_LEVELS)) lamp_cfg.levels = LVL_W'(MAX_LEVELS);
        else lamp_cfg.levels = d[LVL_W-1:0];
      end
      default: ;
    endcase
  endfunction

  // Advance the predictor by one accepted item and return the brightness result
  function automatic lamp_res_t predict_brightness(input logic cmd, input logic [63:0] now,
                                                   input logic [7:0] idx,
                                                   input logic [15:0] cnt);
    lamp_res_t         r;
    logic [63:0]       delta;
    logic [63:0]       top;
    logic [63:0]       num;
    logic [63:0]       den;
    logic [63:0]       inten;
    logic [63:0]       m;
    logic [FILT_W-1:0] f;
    logic [FILT_W-1:0] t;
    r = '0;
    r.skipped = 1'b1;
    if (cmd == CMD_PERIOD) begin
      r.kind = KIND_PERIOD;
      if (!have_ref) begin
        ref_cycles = now;
        have_ref = 1'b1;
      end else begin
        delta = now - ref_cycles;
        if (delta == 64'd0) begin
          period_skipped = 1'b1;
        end else begin
          ref_cycles = now;
          period_len = (delta > 64'(DELTA_MAX)) ? DELTA_MAX : delta[CNT_W-1:0];
          period_skipped = 1'b0;
          r.skipped = 1'b0;
        end
      end
    end else begin
      r.kind = KIND_LAMP;
      r.lamp = idx;
      if (idx >= LAMP_COUNT) begin
        // out-of-range lamp: ignored, level stays zero
      end else if (period_skipped || period_len == '0) begin
        r.level = round_filter(filt_mem[idx]);
      end else begin
        top = 64'(lamp_cfg.levels) - 64'd1;
        num = 64'(cnt) * top * 64'(lamp_cfg.dimming);
        den = 64'(period_len) << 16;
        inten = num / den;
        if (inten > top) inten = top;
        t = FILT_W'(inten << 16);
        f = filt_mem[idx];
        if (t > f) begin
          m = 64'(lamp_cfg.rise_alpha) * 64'(t - f);
          f = f + FILT_W'((m + HALF_Q16) >> 16);
        end else begin
          m = 64'(lamp_cfg.fall_alpha) * 64'(f - t);
          f = f - FILT_W'((m + HALF_Q16) >> 16);
        end
        filt_mem[idx] = f;
        r.skipped = 1'b0;
        r.raw = inten[INT_W-1:0];
        r.level = round_filter(f);
      end
    end
    return r;
  endfunction

  // Offer one item, hold it until the transfer, then record its expected result
  task automatic send_item(input logic cmd, input logic [63:0] cyc, input logic [7:0] idx,
                           input logic [15:0] cnt);
    int gap;
    if (src_idle_en && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 16);
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    cmd_i         <= cmd;
    cycle_count_i <= cyc;
    light_index_i <= idx;
    on_count_i    <= cnt;
    do @(posedge clk_i); while (!in_ready_o);
    expected_q.push_back(predict_brightness(cmd, cyc, idx, cnt));
  endtask

  task automatic send_period(input logic [63:0] now);
    stim_delta = now - stim_now;
    stim_now = now;
    send_item(CMD_PERIOD, now, 8'($urandom), 16'($urandom));
  endtask

  task automatic send_lamp(input logic [7:0] idx, input logic [15:0] cnt);
    send_item(CMD_LAMP, {$urandom, $urandom}, idx, cnt);
  endtask

  // Drop valid and wait until every outstanding result has been checked
  task automatic drain;
    in_valid_i <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic apply_config(input logic [Q16_W-1:0] dim, input logic [Q16_W-1:0] rise,
                              input logic [Q16_W-1:0] fall, input logic [Q16_W-1:0] lvls);
    cfg_idx_e         idx_list [4];
    logic [Q16_W-1:0] val_list [4];
    idx_list = '{CFG_DIMMING, CFG_RISE, CFG_FALL, CFG_LEVELS};
    val_list = '{dim, rise, fall, lvls};
    for (int i = 0; i < 4; i++) begin
      cfg_we_i   <= 1'b1;
      cfg_idx_i  <= idx_list[i];
      cfg_data_i <= val_list[i];
      @(posedge clk_i);
      write_model_reg(idx_list[i], val_list[i]);
    end
    cfg_we_i <= 1'b0;
  endtask

  // Mostly a period start followed by lamp samples scaled to that period;
  // some zero, huge or random-jump deltas and out-of-range lamps mixed in
  task automatic send_random_items(input int n);
    int          sel;
    int          dsel;
    logic [63:0] delta;
    logic [7:0]  idx;
    int unsigned cmax;
    repeat (n) begin
      sel = $urandom_range(0, 99);
      if (sel < 12) begin
        dsel = $urandom_range(0, 19);
        if (dsel == 0) delta = 64'd0;
        else if (dsel == 1) delta = {$urandom, $urandom};
        else if (dsel == 2) delta = 64'($urandom_range(65535, 300000));
        else if (dsel == 3) delta = 64'd1;
        else delta = 64'($urandom_range(1, 4000));
        send_period(stim_now + delta);
      end else begin
        idx = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(LAMP_COUNT, 255))
                                          : 8'($urandom_range(0, LAMP_COUNT - 1));
        cmax = (stim_delta > 64'd58000) ? 65535 : int'(stim_delta + stim_delta / 8);
        if ($urandom_range(0, 6) == 0) send_lamp(idx, 16'($urandom));
        else send_lamp(idx, 16'($urandom_range(0, cmax)));
      end
    end
  endtask

  task automatic test_period_cases;
    logic [63:0] base;
    base = {$urandom, $urandom};
    stim_now = base;
    send_lamp(8'd5, 16'd100);                  // before priming
    send_period(base);                         // first period only primes
    send_period(base);                         // zero delta
    send_lamp(8'd5, 16'd100);                  // skipped period
    send_lamp(8'd200, 16'd100);                // out of range
    send_period(base + 64'd1000);
    send_lamp(8'd0, 16'd1000);
    send_lamp(8'd179, 16'd0);
    send_lamp(8'd180, 16'd500);
    send_lamp(8'd255, 16'hFFFF);
    send_lamp(8'd0, 16'hFFFF);                 // clamp to top level
    send_period(base + 64'h100_0000_0000);     // delta saturates
    send_lamp(8'd0, 16'hFFFF);
    send_lamp(8'd0, 16'd0);                    // fall step
    send_period(64'hFFFF_FFFF_FFFF_FF00);
    send_period(64'h0000_0000_0000_0010);      // counter wraps
    send_lamp(8'd7, 16'd272);
    send_period(64'h0000_0000_0000_0011);      // one-cycle period
    send_lamp(8'd7, 16'd1);
    send_lamp(8'd8, 16'd0);
    send_period(64'h0000_0000_0000_0011);      // zero delta again
    send_lamp(8'd0, 16'd10);                   // skipped, level held
    drain();
  endtask

  task automatic test_register_extremes;
    logic [Q16_W-1:0] dims  [5];
    logic [Q16_W-1:0] rises [5];
    logic [Q16_W-1:0] falls [5];
    logic [Q16_W-1:0] lvls  [5];
    dims  = '{17'd65536, 17'd0,     17'h1FFFF, 17'd32768, 17'd65535};
    rises = '{17'd29491, 17'd65536, 17'h1FFFF, 17'd0,     17'd1};
    falls = '{17'd2621,  17'd65536, 17'h1FFFF, 17'd0,     17'd65535};
    lvls  = '{17'd8,     17'd64,    17'h1FFFF, 17'd0,     17'd37};
    for (int i = 0; i < 5; i++) begin
      apply_config(dims[i], rises[i], falls[i], lvls[i]);
      send_random_items(60);
      drain();
    end
  endtask

  task automatic test_output_stall;
    long_hold_cycles = 300;
    send_random_items(40);
    drain();
  endtask

  task automatic test_random_traffic;
    src_idle_en = 1'b1;
    sink_idle_en = 1'b1;
    for (int i = 0; i < 4; i++) begin
      if ($urandom_range(0, 1) == 0)
        apply_config(17'($urandom_range(32768, 65536)), 17'($urandom_range(0, 65536)),
                     17'($urandom_range(0, 65536)), 17'($urandom_range(8, 64)));
      else
        apply_config(17'($urandom), 17'($urandom), 17'($urandom), 17'($urandom_range(0, 127)));
      send_random_items(350);
      drain();
    end
    // closing stretch at full rate
    src_idle_en = 1'b0;
    sink_idle_en = 1'b0;
    send_random_items(200);
    drain();
  endtask

  // Compare each accepted result with the oldest prediction
  function automatic void check_field(input string name, input int exp_v, input int got_v);
    if (exp_v != got_v) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, got_v);
      err_cnt++;
    end
  endfunction

  initial begin : result_check
    lamp_res_t exp_r;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_valid_o && out_ready_i) begin
        if (expected_q.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual lamp %0d kind %0d",
                   $time, lamp_number_o, kind_o);
          err_cnt++;
        end else begin
          exp_r = expected_q.pop_front();
          check_field("kind", exp_r.kind, kind_o);
          check_field("skipped", exp_r.skipped, skipped_o);
          check_field("lamp_number", exp_r.lamp, lamp_number_o);
          check_field("raw_intensity", exp_r.raw, raw_intensity_o);
          check_field("lamp_level", exp_r.level, lamp_level_o);
        end
      end
    end
  end

  initial begin : result_sink
    int stall_left;
    stall_left = 0;
    out_ready_i <= 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (long_hold_cycles > 0) begin
        stall_left = long_hold_cycles;
        long_hold_cycles = 0;
      end
      if (stall_left > 0) begin
        out_ready_i <= 1'b0;
        stall_left--;
      end else if (sink_idle_en && $urandom_range(0, 7) == 0) begin
        out_ready_i <= 1'b0;
        stall_left = $urandom_range(0, 15);
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  initial begin
    err_cnt          = 0;
    src_idle_en      = 1'b0;
    sink_idle_en     = 1'b0;
    long_hold_cycles = 0;
    stim_now         = '0;
    stim_delta       = '0;
    lamp_cfg         = '{dimming: ONE_Q16, rise_alpha: RISE_RESET, fall_alpha: FALL_RESET,
                         levels: LVL_RESET};
    ref_cycles       = '0;
    have_ref         = 1'b0;
    period_len       = '0;
    period_skipped   = 1'b1;
    foreach (filt_mem[i]) filt_mem[i] = '0;
    rst_ni        <= 1'b0;
    cfg_we_i      <= 1'b0;
    cfg_idx_i     <= CFG_DIMMING;
    cfg_data_i    <= '0;
    in_valid_i    <= 1'b0;
    cmd_i         <= CMD_PERIOD;
    cycle_count_i <= '0;
    light_index_i <= '0;
    on_count_i    <= '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_period_cases();
    test_register_extremes();
    test_output_stall();
    test_random_traffic();

    // catch any stray results after the last expected one
    repeat (40) @(posedge clk_i);
    if (err_cnt == 0) begin
      $display("** lamp_brightness_filter_unit: PASSED **");
    end else begin
      $display("** lamp_brightness_filter_unit: FAILED **");
    end
    $finish;
  end

endmodule
